/* rtl/scpd_pkg.sv */
// Shared types and codes for the checksummed packet deframer.
`timescale 1ns / 1ps
package scpd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned TypeW  = 3;
  localparam int unsigned StatW  = 2;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned ApbW   = 32;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LENGTH = 3'd1,
    PH_TYPE   = 3'd2,
    PH_DATA   = 3'd3,
    PH_CHECK  = 3'd4
  } phase_t;

  typedef enum logic [StatW-1:0] {
    ST_BUSY  = 2'd0,
    ST_DONE  = 2'd1,
    ST_FAIL  = 2'd2,
    ST_STRAY = 2'd3
  } status_t;

  // Register index within the configuration space.
  localparam logic REG_HEADER = 1'b0;

  typedef struct packed {
    status_t              status;
    logic                 data_valid;
    logic [ByteW-1:0]     data_byte;
    logic [ByteW-1:0]     data_index;
    logic [TypeW-1:0]     frame_type;
    logic [ByteW-1:0]     frame_length;
  } result_t;

endpackage

/* rtl/scpd_cfg.sv */
// APB-style configuration register holding the frame header byte.
`timescale 1ns / 1ps
module scpd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scpd_pkg::AddrW-1:0]  paddr,
  input  logic [scpd_pkg::ApbW-1:0]   pwdata,
  output logic [scpd_pkg::ApbW-1:0]   prdata,
  output logic                        pready,
  output logic [scpd_pkg::ByteW-1:0]  header_byte
);

  logic sel_header;

  assign sel_header = (paddr[scpd_pkg::AddrW-1] == scpd_pkg::REG_HEADER);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= '0;
    end else if (psel && penable && pwrite && pready && sel_header) begin
      header_byte <= pwdata[scpd_pkg::ByteW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_header) begin
      prdata[scpd_pkg::ByteW-1:0] = header_byte;
    end
  end

endmodule

/* rtl/scpd_parser.sv */
// Frame parser state and per-byte result computation.
`timescale 1ns / 1ps
module scpd_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [scpd_pkg::ByteW-1:0]  rx_byte,
  input  logic [scpd_pkg::ByteW-1:0]  header_byte,
  output scpd_pkg::result_t           res
);

  scpd_pkg::phase_t             phase, phase_next;
  logic [scpd_pkg::ByteW-1:0]   payload_length, payload_length_next;
  logic [scpd_pkg::TypeW-1:0]   kind, kind_next;
  logic [scpd_pkg::ByteW-1:0]   byte_count, byte_count_next;
  logic [scpd_pkg::ByteW-1:0]   running_sum, running_sum_next;
  logic [scpd_pkg::ByteW:0]     count_plus;
  logic                         stray;

  assign count_plus = {1'b0, byte_count} + {{scpd_pkg::ByteW{1'b0}}, 1'b1};

  always_comb begin
    phase_next          = phase;
    payload_length_next = payload_length;
    kind_next           = kind;
    byte_count_next     = byte_count;
    running_sum_next    = running_sum;
    unique case (phase)
      scpd_pkg::PH_LENGTH: begin
        payload_length_next = rx_byte;
        phase_next          = scpd_pkg::PH_TYPE;
      end
      scpd_pkg::PH_TYPE: begin
        kind_next = rx_byte[scpd_pkg::TypeW-1:0];
        if (rx_byte[scpd_pkg::TypeW-1:0] != '0) begin
          phase_next = (payload_length != '0) ? scpd_pkg::PH_DATA : scpd_pkg::PH_CHECK;
        end
      end
      scpd_pkg::PH_DATA: begin
        running_sum_next = running_sum + rx_byte;
        byte_count_next  = count_plus[scpd_pkg::ByteW-1:0];
        if (count_plus >= {1'b0, payload_length}) begin
          phase_next = scpd_pkg::PH_CHECK;
        end
      end
      scpd_pkg::PH_CHECK: begin
        phase_next = scpd_pkg::PH_IDLE;
      end
      default: begin
        // Unused phase codes behave as idle.
        phase_next = scpd_pkg::PH_IDLE;
        if (rx_byte == header_byte) begin
          phase_next          = scpd_pkg::PH_LENGTH;
          payload_length_next = '0;
          kind_next           = '0;
          byte_count_next     = '0;
          running_sum_next    = '0;
        end
      end
    endcase
  end

  always_comb begin
    stray          = 1'b0;
    res.status     = scpd_pkg::ST_BUSY;
    res.data_valid = 1'b0;
    res.data_byte  = '0;
    res.data_index = '0;
    unique case (phase)
      scpd_pkg::PH_LENGTH, scpd_pkg::PH_TYPE: begin
      end
      scpd_pkg::PH_DATA: begin
        res.data_valid = 1'b1;
        res.data_byte  = rx_byte;
        res.data_index = byte_count;
      end
      scpd_pkg::PH_CHECK: begin
        res.status = (rx_byte == running_sum) ? scpd_pkg::ST_DONE : scpd_pkg::ST_FAIL;
      end
      default: begin
        if (rx_byte != header_byte) begin
          stray      = 1'b1;
          res.status = scpd_pkg::ST_STRAY;
        end
      end
    endcase
    res.frame_type   = stray ? '0 : kind_next;
    res.frame_length = stray ? '0 : payload_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= scpd_pkg::PH_IDLE;
      payload_length <= '0;
      kind           <= '0;
      byte_count     <= '0;
      running_sum    <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      payload_length <= payload_length_next;
      kind           <= kind_next;
      byte_count     <= byte_count_next;
      running_sum    <= running_sum_next;
    end
  end

endmodule

/* rtl/scpd_out_reg.sv */
// Result register that holds one result until the receiver takes it.
`timescale 1ns / 1ps
module scpd_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  scpd_pkg::result_t  res_in,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               can_load,
  output scpd_pkg::result_t  res_out
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

/* rtl/sum_checked_packet_deframer_unit.sv */
// Top level of the checksummed packet deframer.
`timescale 1ns / 1ps
// Usage: received bytes enter on rx_byte with in_valid/in_ready; each request
// yields exactly one result on the output channel (out_valid/out_ready) with
// status, data_valid, data_byte, data_index, frame_type and frame_length.
// A frame is the header byte, a length byte, a type byte (low three bits
// nonzero), that many data bytes and a checksum byte equal to their 8-bit sum.
// The header value is set through the APB port, register 0 at address 0.
// The result register loads on acceptance, so a request's result shows in
// the following cycle. Throughput is one request per cycle while results are
// taken, set by the single result register after the parser's next-state logic.
// in_ready is high whenever the result register is empty or is being taken
// in the same cycle, so a stalled receiver holds the result and stops new
// requests, and no result is lost or repeated.
// Reset clears the parser to idle, the header register to zero and the
// result register to empty; no clearing pass follows.
// Configuration should be written only while no frame is being parsed.
module sum_checked_packet_deframer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scpd_pkg::AddrW-1:0]  paddr,
  input  logic [scpd_pkg::ApbW-1:0]   pwdata,
  output logic [scpd_pkg::ApbW-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [scpd_pkg::ByteW-1:0]  rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [scpd_pkg::StatW-1:0]  status,
  output logic                        data_valid,
  output logic [scpd_pkg::ByteW-1:0]  data_byte,
  output logic [scpd_pkg::ByteW-1:0]  data_index,
  output logic [scpd_pkg::TypeW-1:0]  frame_type,
  output logic [scpd_pkg::ByteW-1:0]  frame_length
);

  logic [scpd_pkg::ByteW-1:0] header_byte;
  logic                       accept;
  scpd_pkg::result_t          res_next;
  scpd_pkg::result_t          res;

  assign accept = in_valid && in_ready;

  scpd_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .header_byte (header_byte)
  );

  scpd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .header_byte (header_byte),
    .res         (res_next)
  );

  scpd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res_in    (res_next),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (in_ready),
    .res_out   (res)
  );

  assign status       = res.status;
  assign data_valid   = res.data_valid;
  assign data_byte    = res.data_byte;
  assign data_index   = res.data_index;
  assign frame_type   = res.frame_type;
  assign frame_length = res.frame_length;

endmodule

/* rtl/scpd_checker.sv */
// Port-level assertions for the deframer and the bind that attaches them.
`timescale 1ns / 1ps
module scpd_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [scpd_pkg::StatW-1:0]  status,
  input  logic                        data_valid,
  input  logic [scpd_pkg::ByteW-1:0]  data_byte,
  input  logic [scpd_pkg::TypeW-1:0]  frame_type,
  input  logic [scpd_pkg::ByteW-1:0]  frame_length
);

  // A stalled result must hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data_byte))
    else $error("result changed while stalled");

  // The block takes a request exactly when its result slot is free.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow result slot");

  // A request accepted yields a result in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  // A stray byte carries no frame information.
  a_stray: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == scpd_pkg::ST_STRAY |->
      !data_valid && frame_type == '0 && frame_length == '0)
    else $error("stray byte reports frame fields");

  // Data bytes only appear inside a frame with a nonzero type.
  a_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_valid |-> status == scpd_pkg::ST_BUSY && frame_type != '0)
    else $error("data byte outside a typed frame");

endmodule

bind sum_checked_packet_deframer_unit scpd_checker u_scpd_checker (.*);

/* dv/testbench.sv */
// Self-checking testbench for the checksummed packet deframer.
`timescale 1ns / 1ps
module testbench;
  import scpd_pkg::*;

  localparam logic [AddrW-1:0] HEADER_ADDR = {REG_HEADER, 2'b00};
  localparam logic [AddrW-1:0] UNUSED_ADDR = 3'd4;
  localparam logic [ByteW-1:0] DIRECTED [19] = '{
    8'h5A,
    8'h00, 8'h02, 8'h08, 8'hFF, 8'hFF, 8'h00, 8'hFF,
    8'h00, 8'h00, 8'h00, 8'h01, 8'h00,
    8'h00, 8'h01, 8'h05, 8'h80, 8'h81,
    8'hFF
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [ApbW-1:0]  pwdata = '0;
  logic [ApbW-1:0]  prdata;
  logic             pready;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [ByteW-1:0] rx_byte = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [StatW-1:0] status;
  logic             data_valid;
  logic [ByteW-1:0] data_byte;
  logic [ByteW-1:0] data_index;
  logic [TypeW-1:0] frame_type;
  logic [ByteW-1:0] frame_length;

  logic [ByteW-1:0] bytes_to_send [$];
  result_t          results_due [$];
  int               items_queued = 0;
  int               errors = 0;
  int               send_idle_pct = 0;
  int               stall_pct = 0;

  logic [ByteW-1:0] header_value = '0;
  phase_t           parse_phase = PH_IDLE;
  logic [ByteW-1:0] frame_len = '0;
  logic [TypeW-1:0] frame_kind = '0;
  logic [ByteW-1:0] payload_count = '0;
  logic [ByteW-1:0] payload_sum = '0;

  sum_checked_packet_deframer_unit uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .data_valid(data_valid), .data_byte(data_byte),
    .data_index(data_index), .frame_type(frame_type), .frame_length(frame_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t deframe_byte(input logic [ByteW-1:0] b);
    result_t r;
    r = '0;
    r.status = ST_BUSY;
    case (parse_phase)
      PH_LENGTH: begin
        frame_len = b;
        parse_phase = PH_TYPE;
      end
      PH_TYPE: begin
        frame_kind = b[TypeW-1:0];
        if (frame_kind != '0) parse_phase = (frame_len != '0) ? PH_DATA : PH_CHECK;
      end
      PH_DATA: begin
        r.data_valid = 1'b1;
        r.data_byte = b;
        r.data_index = payload_count;
        payload_sum = payload_sum + b;
        if ({1'b0, payload_count} + 9'd1 >= {1'b0, frame_len}) parse_phase = PH_CHECK;
        payload_count = payload_count + 8'd1;
      end
      PH_CHECK: begin
        r.status = (b == payload_sum) ? ST_DONE : ST_FAIL;
        parse_phase = PH_IDLE;
      end
      default: begin
        if (b == header_value) begin
          parse_phase = PH_LENGTH;
          frame_len = '0;
          frame_kind = '0;
          payload_count = '0;
          payload_sum = '0;
        end else begin
          r.status = ST_STRAY;
        end
      end
    endcase
    if (r.status != ST_STRAY) begin
      r.frame_type = frame_kind;
      r.frame_length = frame_len;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) results_due.push_back(deframe_byte(rx_byte));
      if (!in_valid || in_ready) begin
        if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          rx_byte <= bytes_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 200)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual status %0d",
                   $time, status);
        end else begin
          want = results_due.pop_front();
          check_field("status", want.status, status);
          check_field("data_valid", want.data_valid, data_valid);
          check_field("data_byte", want.data_byte, data_byte);
          check_field("data_index", want.data_index, data_index);
          check_field("frame_type", want.frame_type, frame_type);
          check_field("frame_length", want.frame_length, frame_length);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic apb_access(input logic wr, input logic [AddrW-1:0] addr,
                            input logic [ApbW-1:0] wdata, output logic [ApbW-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_header_reg();
    logic [ApbW-1:0] rdata;
    apb_access(1'b0, HEADER_ADDR, '0, rdata);
    check_field("header_byte readback", header_value, rdata[ByteW-1:0]);
  endtask

  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [ByteW-1:0] value);
    logic [ApbW-1:0] rdata;
    apb_access(1'b1, addr, {24'($urandom), value}, rdata);
    if (addr == HEADER_ADDR) header_value = value;
  endtask

  function automatic void push_byte(input logic [ByteW-1:0] b);
    bytes_to_send.push_back(b);
    items_queued++;
  endfunction

  // A frame may be cut short after keep bytes; keep of zero sends it whole.
  function automatic void queue_frame(input int len, input bit good, input int keep);
    logic [ByteW-1:0] frame [$];
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] total;
    total = '0;
    frame.push_back(header_value);
    frame.push_back(8'(len));
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
      frame.push_back({5'($urandom), 3'b000});
    frame.push_back({5'($urandom), 3'($urandom_range(1, 7))});
    for (int i = 0; i < len; i++) begin
      b = ($urandom_range(0, 9) == 0) ? header_value : 8'($urandom);
      total = total + b;
      frame.push_back(b);
    end
    frame.push_back(good ? total : total + 8'($urandom_range(1, 255)));
    if (keep == 0 || keep > frame.size()) keep = frame.size();
    for (int i = 0; i < keep; i++) push_byte(frame[i]);
  endfunction

  function automatic void queue_traffic(input int target);
    int start;
    int len;
    start = items_queued;
    while (items_queued - start < target) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
        1: queue_frame(len, 1'b1, $urandom_range(1, 6));
        default: queue_frame(len, $urandom_range(0, 4) != 0, 0);
      endcase
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (bytes_to_send.size() != 0 || in_valid || results_due.size() != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Leaves the parser idle so that the header can be changed safely.
  task automatic settle();
    wait_drained();
    while (parse_phase != PH_IDLE) begin
      push_byte(8'h01);
      wait_drained();
    end
  endtask

  initial begin : sequencer
    logic [ByteW-1:0] hdr;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_header_reg();
    @(negedge clk);
    foreach (DIRECTED[i]) push_byte(DIRECTED[i]);
    settle();
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: hdr = 8'hFF;
        1: hdr = 8'h00;
        default: hdr = 8'($urandom);
      endcase
      write_reg(HEADER_ADDR, hdr);
      if (p == 4) write_reg(UNUSED_ADDR, 8'($urandom));
      check_header_reg();
      case (p % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 75; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 75; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      @(negedge clk);
      if (p == 5) queue_frame(255, 1'b1, 0);
      queue_traffic(250);
      settle();
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
